>>> sv/dvr_pkg.sv
// ----------------------------------------------------------------------------
// Distance-vector route lookup package
// Shared widths, codes, control-word layout and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package dvr_pkg;

  // Default table size in nodes.
  localparam int unsigned DVR_MAX_NODES = 16;

  // Fixed field widths of the stream items and the register.
  localparam int unsigned NODE_W      = 4;
  localparam int unsigned COST_W      = 8;
  localparam int unsigned DIST_W      = 9;
  localparam int unsigned ENTRY_W     = COST_W + 1;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  // Register index decoded from paddr[2].
  localparam logic REG_NODE_COUNT = 1'b0;

  // Request kinds.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Program steps.
  typedef enum logic [2:0] {
    STEP_CLEAR,
    STEP_WAIT,
    STEP_WR_AB,
    STEP_WR_BA,
    STEP_RD_DIRECT,
    STEP_INIT,
    STEP_SCAN,
    STEP_OUT
  } dvr_step_e;

  // Hold conditions: the step repeats while the condition is true.
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_NO_INPUT,
    WAIT_OUT_BUSY
  } dvr_wait_e;

  // Jump conditions: taken to the target when true, else fall through.
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_IN_QUERY,
    JMP_CLEAR_MORE,
    JMP_SCAN_MORE,
    JMP_NO_SCAN
  } dvr_jump_e;

  // One control word of the program.
  typedef struct packed {
    logic      s_ready;
    logic      clr_wr;
    logic      wr_ab;
    logic      wr_ba;
    logic      rd_direct;
    logic      init;
    logic      scan;
    logic      out_load;
    dvr_wait_e wait_sel;
    dvr_jump_e jump_sel;
    dvr_step_e target;
  } dvr_ctl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic in_query;
    logic out_busy;
    logic clear_more;
    logic scan_more;
    logic no_scan;
  } dvr_status_t;

  // Microcode ROM.
  function automatic dvr_ctl_t dvr_rom(input dvr_step_e step);
    dvr_ctl_t cw;
    cw          = '0;
    cw.wait_sel = WAIT_NONE;
    cw.jump_sel = JMP_NEVER;
    cw.target   = STEP_CLEAR;
    case (step)
      STEP_CLEAR: begin
        cw.clr_wr   = 1'b1;
        cw.jump_sel = JMP_CLEAR_MORE;
        cw.target   = STEP_CLEAR;
      end
      STEP_WAIT: begin
        cw.s_ready  = 1'b1;
        cw.wait_sel = WAIT_NO_INPUT;
        cw.jump_sel = JMP_IN_QUERY;
        cw.target   = STEP_RD_DIRECT;
      end
      STEP_WR_AB: begin
        cw.wr_ab = 1'b1;
      end
      STEP_WR_BA: begin
        cw.wr_ba    = 1'b1;
        cw.jump_sel = JMP_ALWAYS;
        cw.target   = STEP_WAIT;
      end
      STEP_RD_DIRECT: begin
        cw.rd_direct = 1'b1;
      end
      STEP_INIT: begin
        cw.init     = 1'b1;
        cw.jump_sel = JMP_NO_SCAN;
        cw.target   = STEP_OUT;
      end
      STEP_SCAN: begin
        cw.scan     = 1'b1;
        cw.jump_sel = JMP_SCAN_MORE;
        cw.target   = STEP_SCAN;
      end
      STEP_OUT: begin
        cw.out_load = 1'b1;
        cw.wait_sel = WAIT_OUT_BUSY;
        cw.jump_sel = JMP_ALWAYS;
        cw.target   = STEP_WAIT;
      end
      default: begin
        cw.jump_sel = JMP_ALWAYS;
        cw.target   = STEP_CLEAR;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> sv/dvr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/dvr_seq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the program ROM with hold and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_seq
  import dvr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dvr_status_t stat_i,
  output dvr_ctl_t         ctl_o,
  output dvr_step_e        step_o
);

  dvr_step_e pc_q, pc_d;
  logic      wait_hit;
  logic      jump_hit;

  // Step register; reset starts the table clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Fetch the control word and choose the next step.
  always_comb begin
    ctl_o = dvr_rom(pc_q);

    case (ctl_o.wait_sel)
      WAIT_NONE:     wait_hit = 1'b0;
      WAIT_NO_INPUT: wait_hit = !stat_i.in_valid;
      WAIT_OUT_BUSY: wait_hit = stat_i.out_busy;
      default:       wait_hit = 1'b0;
    endcase

    case (ctl_o.jump_sel)
      JMP_NEVER:      jump_hit = 1'b0;
      JMP_ALWAYS:     jump_hit = 1'b1;
      JMP_IN_QUERY:   jump_hit = stat_i.in_query;
      JMP_CLEAR_MORE: jump_hit = stat_i.clear_more;
      JMP_SCAN_MORE:  jump_hit = stat_i.scan_more;
      JMP_NO_SCAN:    jump_hit = stat_i.no_scan;
      default:        jump_hit = 1'b0;
    endcase

    if (wait_hit) begin
      pc_d = pc_q;
    end else if (jump_hit) begin
      pc_d = ctl_o.target;
    end else begin
      pc_d = dvr_step_e'(3'(pc_q + 3'd1));
    end
  end

  assign step_o = pc_q;

endmodule

`default_nettype wire

>>> sv/distance_vector_route_lookup.sv
// ----------------------------------------------------------------------------
// Distance-vector route lookup
// Two-hop best-route search over a symmetric link-cost table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the link table, one entry
// per cycle over all (2**clog2(MAX_NODES))**2 entries (256 at the default
// size), and accepts no request until it ends. A link write is accepted and
// then written once per direction. A route query reads the direct link and
// then scans L nodes, where L is node_count capped at MAX_NODES: the scan
// reads one intermediate node per cycle, limited by the single read port of
// each of the two table copies. A finished result waits in an output
// register, so the next request is taken while it is still pending.
`default_nettype none

module distance_vector_route_lookup
  import dvr_pkg::*;
#(
  parameter int unsigned MAX_NODES = DVR_MAX_NODES
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Request stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [0] action, [4:1] node_a, [8:5] node_b, [16:9] link_cost, [17] link_present
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] reachable, [9:1] route_distance, [13:10] next_hop
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration port.
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  output logic      [APB_DW-1:0]      prdata,
  output logic                        pready
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned CW    = NW + 1;
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned DEPTH = 1 << AW;

  dvr_ctl_t    ctl;
  dvr_status_t stat;
  dvr_step_e   step;

  // Request fields.
  logic              in_action;
  logic [NODE_W-1:0] in_a;
  logic [NODE_W-1:0] in_b;
  logic [COST_W-1:0] in_cost;
  logic              in_present;
  logic              in_accept;

  logic [NODE_W-1:0] a_q, b_q;
  logic [COST_W-1:0] cost_q;
  logic              present_q;
  logic [CNT_W-1:0]  node_count_q;

  logic [NW-1:0]     a_idx, b_idx;
  logic              a_in_range, b_in_range;
  logic [CW-1:0]     limit;

  logic [NW-1:0]     k_q, k_d;
  logic [AW-1:0]     clr_q;

  logic               wr_en;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      raddr0, raddr1;
  logic [ENTRY_W-1:0] rdata0, rdata1;
  logic [DIST_W-1:0]  sum;

  logic              ok_q;
  logic [DIST_W-1:0] dist_q;
  logic [NODE_W-1:0] hop_q;

  logic              out_valid_q;
  logic              out_reach_q;
  logic [DIST_W-1:0] out_dist_q;
  logic [NODE_W-1:0] out_hop_q;
  logic              out_fire;
  logic              out_busy_w;
  logic              cfg_wr;

  // Unpack the request.
  assign in_action  = s_axis_tdata[0];
  assign in_a       = s_axis_tdata[4:1];
  assign in_b       = s_axis_tdata[8:5];
  assign in_cost    = s_axis_tdata[16:9];
  assign in_present = s_axis_tdata[17];

  assign s_axis_tready = ctl.s_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Latch the request fields.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q       <= in_a;
      b_q       <= in_b;
      cost_q    <= in_cost;
      present_q <= in_present;
    end
  end

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
      node_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DW'(node_count_q) : '0;

  // Node indexes, range checks and the scan limit.
  assign a_idx      = NW'(a_q);
  assign b_idx      = NW'(b_q);
  assign a_in_range = 32'(a_q) < MAX_NODES;
  assign b_in_range = 32'(b_q) < MAX_NODES;
  assign limit      = (32'(node_count_q) > MAX_NODES) ? CW'(MAX_NODES)
                                                       : CW'(node_count_q);

  // Status for the sequencer.
  assign out_busy_w = out_valid_q && !m_axis_tready;

  always_comb begin
    stat.in_valid   = s_axis_tvalid;
    stat.in_query   = (in_action == ACT_QUERY);
    stat.out_busy   = out_busy_w;
    stat.clear_more = (clr_q != '1);
    stat.scan_more  = (CW'(k_q) + CW'(1)) < limit;
    stat.no_scan    = !(a_in_range && b_in_range) || (limit == '0);
  end

  dvr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl),
    .step_o (step)
  );

  // Clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Table write: clearing pass, or a link written in both directions.
  always_comb begin
    wr_en = ctl.clr_wr ||
            ((ctl.wr_ab || ctl.wr_ba) && a_in_range && b_in_range && (a_q != b_q));
    if (ctl.clr_wr) begin
      waddr = clr_q;
      wdata = (clr_q[AW-1:NW] == clr_q[NW-1:0]) ? {1'b1, COST_W'(0)} : '0;
    end else begin
      waddr = ctl.wr_ab ? {a_idx, b_idx} : {b_idx, a_idx};
      wdata = present_q ? {1'b1, cost_q} : '0;
    end
  end

  // Scan index; reads run one step ahead of the compare.
  always_comb begin
    if (ctl.rd_direct) begin
      k_d = '0;
    end else if (ctl.scan) begin
      k_d = k_q + NW'(1);
    end else begin
      k_d = k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  // Copy 0 is read along the source row, copy 1 along the destination row.
  assign raddr0 = ctl.rd_direct ? {a_idx, b_idx} : {a_idx, k_d};
  assign raddr1 = {b_idx, k_d};

  dvr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_tab_src (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr0),
    .rdata_o (rdata0)
  );

  dvr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_tab_dst (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  // Two-hop cost through the current intermediate node.
  assign sum = {1'b0, rdata0[COST_W-1:0]} + {1'b0, rdata1[COST_W-1:0]};

  // Best route so far: direct link first, then strictly shorter detours.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q   <= 1'b0;
      dist_q <= '0;
      hop_q  <= '0;
    end else if (ctl.init) begin
      ok_q   <= a_in_range && b_in_range && rdata0[COST_W];
      dist_q <= (a_in_range && b_in_range && rdata0[COST_W])
                ? {1'b0, rdata0[COST_W-1:0]} : '0;
      hop_q  <= a_q;
    end else if (ctl.scan) begin
      if (rdata0[COST_W] && rdata1[COST_W] && (!ok_q || (sum < dist_q))) begin
        ok_q   <= 1'b1;
        dist_q <= sum;
        hop_q  <= NODE_W'(k_q);
      end
    end
  end

  // Output register.
  assign out_fire = ctl.out_load && !out_busy_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_reach_q <= ok_q;
      out_dist_q  <= dist_q;
      out_hop_q   <= hop_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_hop_q, out_dist_q, out_reach_q};

  // A pending result is never overwritten.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> !(out_valid_q && !m_axis_tready))
    else $error("result register overwritten while pending");

  // The scan only visits intermediate nodes below the limit.
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.scan |-> (CW'(k_q) < limit))
    else $error("scan index beyond node limit");

  // Link writes never touch the diagonal.
  a_no_diag_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !ctl.clr_wr) |-> (waddr[AW-1:NW] != waddr[NW-1:0]))
    else $error("link write hit the diagonal");

  // Requests are taken only in the wait step, never during the clearing pass.
  a_ready_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (step == STEP_WAIT) && !ctl.clr_wr)
    else $error("request taken outside the wait step");

endmodule

`default_nettype wire

>>> tb/distance_vector_route_lookup_checker.sv
// ----------------------------------------------------------------------------
// Distance-vector route lookup checker
// Watches the request, result and configuration channels, keeps its own copy
// of the link table and node count, and compares every result with the route
// it predicts for the matching query.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_lookup_checker
  import dvr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  // [0] action, [4:1] node_a, [8:5] node_b, [16:9] link_cost, [17] link_present
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] reachable, [9:1] route_distance, [13:10] next_hop
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  input  wire logic                   pready,
  output int                          routes_pending_o,
  output int                          mismatch_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES = DVR_MAX_NODES;

  typedef struct packed {
    logic [IN_TDATA_W-2*NODE_W-COST_W-3:0] pad;
    logic                                  link_present;
    logic [COST_W-1:0]                     link_cost;
    logic [NODE_W-1:0]                     node_b;
    logic [NODE_W-1:0]                     node_a;
    logic                                  action;
  } request_t;

  typedef struct packed {
    logic [OUT_TDATA_W-NODE_W-DIST_W-2:0] pad;
    logic [NODE_W-1:0]                    next_hop;
    logic [DIST_W-1:0]                    route_distance;
    logic                                 reachable;
  } route_t;

  // Bit COST_W of an entry marks a present link, the low bits hold its cost.
  logic [ENTRY_W-1:0] link_table [NODES][NODES];
  logic [CNT_W-1:0]   node_count_q;
  route_t             expected_routes [$];
  int                 mismatches;

  // Direct link first, then one relaxation round over the intermediates.
  function automatic route_t best_route(input logic [NODE_W-1:0] src,
                                        input logic [NODE_W-1:0] dst);
    route_t            r;
    int unsigned       span;
    int unsigned       k;
    logic [DIST_W-1:0] via;
    r                = '0;
    r.reachable      = link_table[src][dst][COST_W];
    r.route_distance = r.reachable ? DIST_W'(link_table[src][dst][COST_W-1:0]) : '0;
    r.next_hop       = src;
    span = (node_count_q > NODES) ? NODES : node_count_q;
    for (k = 0; k < span; k++) begin
      if (link_table[src][k][COST_W] && link_table[k][dst][COST_W]) begin
        via = DIST_W'(link_table[src][k][COST_W-1:0]) +
              DIST_W'(link_table[k][dst][COST_W-1:0]);
        if (!r.reachable || via < r.route_distance) begin
          r.reachable      = 1'b1;
          r.route_distance = via;
          r.next_hop       = NODE_W'(k);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    request_t req;
    route_t   got;
    route_t   want;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        for (int j = 0; j < NODES; j++) begin
          link_table[i][j] = (i == j) ? {1'b1, {COST_W{1'b0}}} : '0;
        end
      end
      node_count_q = NODE_COUNT_RST;
      expected_routes.delete();
      mismatches = 0;
    end else begin
      // Results are matched before this edge's request is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        got = route_t'(m_axis_tdata);
        if (expected_routes.size() == 0) begin
          $error("route result with no query outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_routes.pop_front();
          if (got.reachable !== want.reachable) begin
            $error("reachable: expected %0d, actual %0d", want.reachable, got.reachable);
            mismatches++;
          end
          if (got.route_distance !== want.route_distance) begin
            $error("route_distance: expected %0d, actual %0d",
                   want.route_distance, got.route_distance);
            mismatches++;
          end
          if (got.next_hop !== want.next_hop) begin
            $error("next_hop: expected %0d, actual %0d", want.next_hop, got.next_hop);
            mismatches++;
          end
        end
      end

      // Link writes update both directions; the diagonal stays fixed.
      if (s_axis_tvalid && s_axis_tready) begin
        req = request_t'(s_axis_tdata);
        if (req.action == ACT_WRITE) begin
          if (req.node_a != req.node_b) begin
            link_table[req.node_a][req.node_b] =
              req.link_present ? {1'b1, req.link_cost} : '0;
            link_table[req.node_b][req.node_a] =
              req.link_present ? {1'b1, req.link_cost} : '0;
          end
        end else begin
          expected_routes.push_back(best_route(req.node_a, req.node_b));
        end
      end

      // Only the node count register exists; other indexes are dropped.
      if (psel && penable && pwrite && pready &&
          paddr[APB_AW-1:2] == REG_NODE_COUNT) begin
        node_count_q = pwdata[CNT_W-1:0];
      end
    end
    routes_pending_o <= expected_routes.size();
    mismatch_count_o <= mismatches;
  end

endmodule

`default_nettype wire

>>> tb/distance_vector_route_lookup_tb.sv
// ----------------------------------------------------------------------------
// Distance-vector route lookup testbench
// Drives directed and random link writes and route queries through several
// node counts and idle profiles, stalls the result side for a long stretch,
// and takes the verdict from the checker running beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_lookup_tb;

  import dvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 4;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 300;

  localparam logic [APB_AW-1:0] ADDR_NODE_COUNT = APB_AW'(0);
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED   = APB_AW'(4);

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [0] action, [4:1] node_a, [8:5] node_b, [16:9] link_cost, [17] link_present
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [0] reachable, [9:1] route_distance, [13:10] next_hop
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  int routes_pending;
  int mismatch_count;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_requests = 0;
  int quiet_cycles  = 0;

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  distance_vector_route_lookup #(
    .MAX_NODES(DVR_MAX_NODES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  distance_vector_route_lookup_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .routes_pending_o(routes_pending),
    .mismatch_count_o(mismatch_count)
  );

  // Result side: random back-pressure, or a long hold-off when requested.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Ends the run when no channel has moved for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_request(
    input logic              action,
    input logic [NODE_W-1:0] node_a,
    input logic [NODE_W-1:0] node_b,
    input logic [COST_W-1:0] link_cost,
    input logic              link_present
  );
    return IN_TDATA_W'({link_present, link_cost, node_b, node_a, action});
  endfunction

  // Offers one request after a random gap and returns at its accepting edge.
  task automatic offer_request(input logic [IN_TDATA_W-1:0] word);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic link_write(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                            input logic [COST_W-1:0] cost, input logic present);
    offer_request(pack_request(ACT_WRITE, a, b, cost, present));
  endtask

  task automatic route_query(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    offer_request(pack_request(ACT_QUERY, a, b, COST_W'($urandom()), 1'($urandom())));
  endtask

  // Random traffic; a narrow node range makes the table dense.
  task automatic offer_random_request(input int unsigned top_node);
    logic              action;
    logic [COST_W-1:0] cost;
    action = ($urandom_range(0, 99) < 45) ? ACT_WRITE : ACT_QUERY;
    cost   = ($urandom_range(0, 1) == 0) ? COST_W'($urandom()) :
                                           COST_W'($urandom_range(0, 15));
    offer_request(pack_request(action, NODE_W'($urandom_range(0, top_node)),
                               NODE_W'($urandom_range(0, top_node)), cost,
                               $urandom_range(0, 99) < 85));
  endtask

  // Stops offering and waits until every predicted route has come back.
  task automatic drain_routes();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (routes_pending != 0);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reconfigures only once the block is idle, then runs random traffic.
  task automatic run_phase(input logic [CNT_W-1:0] node_count, input int src_pct,
                           input int sink_pct, input int items);
    drain_routes();
    repeat (SETTLE) @(posedge clk_i);
    apb_write(ADDR_NODE_COUNT, APB_DW'(node_count));
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < items; n++) begin
      offer_random_request(($urandom_range(0, 3) == 0) ? 5 : 15);
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_write(ADDR_NODE_COUNT, APB_DW'(16));
    src_idle_pct  = 21;
    sink_idle_pct = 66;

    // Directed: self route, empty table, diagonal write, cost extremes,
    // equal-cost ties, direct link kept on a tie, link removal.
    route_query(4'd3, 4'd3);
    route_query(4'd0, 4'd15);
    link_write(4'd5, 4'd5, 8'd7, 1'b1);
    route_query(4'd5, 4'd5);
    link_write(4'd0, 4'd15, 8'd255, 1'b1);
    route_query(4'd15, 4'd0);
    link_write(4'd0, 4'd7, 8'd0, 1'b1);
    link_write(4'd7, 4'd15, 8'd0, 1'b1);
    route_query(4'd0, 4'd15);
    link_write(4'd1, 4'd2, 8'd255, 1'b1);
    link_write(4'd2, 4'd3, 8'd255, 1'b1);
    route_query(4'd1, 4'd3);
    link_write(4'd4, 4'd6, 8'd10, 1'b1);
    link_write(4'd6, 4'd8, 8'd10, 1'b1);
    link_write(4'd4, 4'd9, 8'd10, 1'b1);
    link_write(4'd9, 4'd8, 8'd10, 1'b1);
    route_query(4'd8, 4'd4);
    link_write(4'd4, 4'd8, 8'd20, 1'b1);
    route_query(4'd4, 4'd8);
    link_write(4'd0, 4'd15, 8'd99, 1'b0);
    route_query(4'd0, 4'd15);
    link_write(4'd7, 4'd15, 8'd255, 1'b0);
    route_query(4'd15, 4'd0);

    // Node count at both ends of its range, with and without idling.
    run_phase(5'd16, 21, 66, 300);
    run_phase(5'd0, 21, 66, 80);
    run_phase(5'd31, 66, 21, 150);
    drain_routes();
    repeat (SETTLE) @(posedge clk_i);
    apb_write(ADDR_UNMAPPED, APB_DW'(3));
    run_phase(5'd1, 66, 21, 80);
    run_phase(5'd9, 0, 0, 100);
    drain_routes();
    for (int n = 0; n < 100; n++) begin
      offer_random_request(15);
    end

    // Hold off the result side while requests keep coming.
    run_phase(5'd16, 0, 0, 50);
    hold_requests++;
    for (int n = 0; n < 270; n++) begin
      offer_random_request(($urandom_range(0, 3) == 0) ? 5 : 15);
    end

    drain_routes();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
